[rtl/mxq_pkg.sv]
package mxq_pkg;

	localparam int MESH_COLS = 8;
	localparam int MESH_ROWS = 8;
	localparam int NUM_LINKS = MESH_COLS * MESH_ROWS * 4;
	localparam int LINK_W    = $clog2(NUM_LINKS);

	localparam int COORD_W = 3;
	localparam int PHASE_W = 32;
	localparam int RTT_W   = 25;
	localparam int FLITS_W = 5;
	localparam int HOPS_W  = 14;
	localparam int WAIT_W  = 36;
	localparam int CNT_W   = 32;

	// shared shift-subtract divider
	localparam int DIVR_W = 52;
	localparam int NUM_W  = 36;
	localparam int STEP_W = 6;

	localparam int RHO_STEPS   = 16;
	localparam int FRESH_STEPS = 33;

	localparam logic [15:0]       RHO_CAP   = 16'd65208;
	localparam logic [NUM_W-1:0]  DELAY_CAP = 36'd4096000000;
	localparam logic [RTT_W-1:0]  RTT_MAX   = {RTT_W{1'b1}};

	localparam logic [1:0] DIR_XP = 2'd0;
	localparam logic [1:0] DIR_XN = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_YN = 2'd3;

	localparam logic [2:0] REG_HOP_X   = 3'd0;
	localparam logic [2:0] REG_HOP_Y   = 3'd1;
	localparam logic [2:0] REG_LINE    = 3'd2;
	localparam logic [2:0] REG_PHASE   = 3'd3;
	localparam logic [2:0] REG_SERVICE = 3'd4;

	typedef struct packed {
		logic [7:0]  hop_x;
		logic [7:0]  hop_y;
		logic [8:0]  line_size;
		logic [19:0] phase_len;
		logic [4:0]  service;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_WIN,
		OP_READ,
		OP_FS,
		OP_RHO_START,
		OP_FRESH_START,
		OP_BLEND_START,
		OP_WRITE,
		OP_ROUTE_RD,
		OP_ROUTE_UPD,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		logic cnt_last;
		logic refresh;
		logic div_busy;
		logic at_dest;
		logic out_full;
	} dp_status_t;

	function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v, int limit);
		logic [COORD_W-1:0] r;
		r = v;
		if (int'(v) >= limit) r = COORD_W'(limit - 1);
		return r;
	endfunction

	function automatic logic [LINK_W-1:0] link_index(logic [COORD_W-1:0] x,
		logic [COORD_W-1:0] y, logic [1:0] d);
		int idx;
		idx = (int'(y) * MESH_COLS + int'(x)) * 4 + int'(d);
		return idx[LINK_W-1:0];
	endfunction

endpackage

[rtl/mxq_ram.sv]
module mxq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/mxq_div.sv]
module mxq_div import mxq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVR_W-1:0] r_init,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIVR_W-1:0] divisor,
	input  logic [STEP_W-1:0] steps,
	output logic              busy,
	output logic [NUM_W-1:0]  quo
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVR_W-1:0] r_q;
	logic [DIVR_W-1:0] d_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              ge;
	logic [DIVR_W-1:0] r_nx;

	always_comb begin
		trial = {r_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
		r_nx  = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= r_init;
			d_q   <= divisor;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			r_q   <= r_nx;
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

[rtl/mxq_datapath.sv]
module mxq_datapath import mxq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	input  cfg_t               cfg,
	input  logic [COORD_W-1:0] src_x,
	input  logic [COORD_W-1:0] src_y,
	input  logic [COORD_W-1:0] dst_x,
	input  logic [COORD_W-1:0] dst_y,
	input  logic               is_invalidate,
	input  logic [PHASE_W-1:0] current_phase,
	output dp_status_t         st,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [RTT_W-1:0]   rtt_cycles
);

	logic [COORD_W-1:0] x_q, y_q, dx_q, dy_q;
	logic               turn_q;
	logic [FLITS_W-1:0] flits_q;
	logic [PHASE_W-1:0] last_phase_q;
	logic [PHASE_W-1:0] delta_q;
	logic [DIVR_W-1:0]  window_q;
	logic [LINK_W-1:0]  cnt_q;
	logic [36:0]        fs_q;
	logic [31:0]        old_q;
	logic               sat_q;
	logic [LINK_W-1:0]  addr_q;
	logic [1:0]         dir_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [HOPS_W-1:0]  hops_q;
	logic               out_valid_q;
	logic [RTT_W-1:0]   rtt_q;
	logic [2:0]         bstep_q;
	logic [NUM_W-1:0]   bx_q;
	logic [NUM_W-1:0]   bq_q;

	logic [COORD_W-1:0] sx_c, sy_c, dx_c, dy_c;
	logic [9:0]         line_up;
	logic [FLITS_W-1:0] flits_c;
	logic [1:0]         dir_c;
	logic [LINK_W-1:0]  link_c;

	logic               ram_we_delay, ram_we_flits;
	logic [LINK_W-1:0]  ram_waddr, ram_raddr;
	logic [31:0]        wdata_delay, wdata_flits;
	logic [31:0]        rd_delay, rd_flits;
	logic [32:0]        flit_sum;

	logic               div_start, div_busy;
	logic [DIVR_W-1:0]  div_r, div_d;
	logic [NUM_W-1:0]   div_num, div_quo;
	logic [STEP_W-1:0]  div_steps;

	logic [15:0]        rho_c;
	logic [20:0]        rs_c;
	logic [16:0]        one_minus;
	logic [32:0]        fresh_c;
	logic [NUM_W-1:0]   blend_sum;
	logic [31:0]        blend_c;
	logic [25:0]        base_c;
	logic [26:0]        total_c;

	always_comb begin
		sx_c    = clamp_coord(src_x, MESH_COLS);
		sy_c    = clamp_coord(src_y, MESH_ROWS);
		dx_c    = clamp_coord(dst_x, MESH_COLS);
		dy_c    = clamp_coord(dst_y, MESH_ROWS);
		line_up = 10'(cfg.line_size) + 10'd31;
		flits_c = is_invalidate ? FLITS_W'(1) : line_up[9:5];
		if (flits_c == '0) flits_c = FLITS_W'(1);
	end

	// XY order: finish x before moving in y
	always_comb begin
		if (x_q != dx_q) dir_c = (x_q < dx_q) ? DIR_XP : DIR_XN;
		else dir_c = (y_q < dy_q) ? DIR_YP : DIR_YN;
		link_c = link_index(x_q, y_q, dir_c);
	end

	always_comb begin
		rho_c = sat_q ? RHO_CAP : ((div_quo[15:0] > RHO_CAP) ? RHO_CAP : div_quo[15:0]);
		rs_c      = 21'(rho_c) * 21'(cfg.service);
		one_minus = 17'h10000 - 17'(rho_c);
		fresh_c   = div_quo[32:0];
		blend_sum = (NUM_W'(old_q) << 3) - NUM_W'(old_q)
			+ (NUM_W'(fresh_c) << 1) + NUM_W'(fresh_c);
		blend_c   = (bq_q > DELAY_CAP) ? DELAY_CAP[31:0] : bq_q[31:0];
	end

	always_comb begin
		div_start = 1'b0;
		div_r     = '0;
		div_num   = '0;
		div_d     = window_q;
		div_steps = STEP_W'(RHO_STEPS);
		case (op)
			OP_RHO_START: begin
				div_start = 1'b1;
				div_r     = DIVR_W'(fs_q);
			end
			OP_FRESH_START: begin
				div_start = 1'b1;
				div_num   = {rs_c, 12'd0, 3'd0};
				div_d     = DIVR_W'({one_minus, 1'b0});
				div_steps = STEP_W'(FRESH_STEPS);
			end
			default: ;
		endcase
	end

	mxq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.r_init  (div_r),
		.num     (div_num),
		.divisor (div_d),
		.steps   (div_steps),
		.busy    (div_busy),
		.quo     (div_quo)
	);

	// divide the blend sum by ten: reciprocal series, then one correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstep_q <= '0;
		end else if (op == OP_BLEND_START) begin
			bstep_q <= 3'd7;
		end else if (bstep_q != '0) begin
			bstep_q <= bstep_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_BLEND_START) begin
			bx_q <= blend_sum;
		end else begin
			case (bstep_q)
				3'd7: bq_q <= (bx_q >> 1) + (bx_q >> 2);
				3'd6: bq_q <= bq_q + (bq_q >> 4);
				3'd5: bq_q <= bq_q + (bq_q >> 8);
				3'd4: bq_q <= bq_q + (bq_q >> 16);
				3'd3: bq_q <= (bq_q + (bq_q >> 32)) >> 3;
				// remainder against the estimate, which is low by at most one
				3'd2: bx_q <= bx_q - (bq_q << 3) - (bq_q << 1);
				3'd1: bq_q <= bq_q + NUM_W'(bx_q > NUM_W'(9));
				default: ;
			endcase
		end
	end

	always_comb begin
		flit_sum     = 33'(rd_flits) + 33'(flits_q);
		ram_we_delay = (op == OP_CLEAR) || (op == OP_WRITE);
		ram_we_flits = ram_we_delay || (op == OP_ROUTE_UPD);
		ram_waddr    = (op == OP_ROUTE_UPD) ? addr_q : cnt_q;
		ram_raddr    = (op == OP_ROUTE_RD) ? link_c : cnt_q;
		wdata_delay  = (op == OP_WRITE) ? blend_c : '0;
		if (op == OP_ROUTE_UPD) begin
			wdata_flits = flit_sum[32] ? 32'hFFFF_FFFF : flit_sum[31:0];
		end else begin
			wdata_flits = '0;
		end
	end

	mxq_ram #(.WIDTH(32), .DEPTH(NUM_LINKS)) u_delay_ram (
		.clk   (clk),
		.we    (ram_we_delay),
		.waddr (ram_waddr),
		.wdata (wdata_delay),
		.raddr (ram_raddr),
		.rdata (rd_delay)
	);

	mxq_ram #(.WIDTH(32), .DEPTH(NUM_LINKS)) u_flits_ram (
		.clk   (clk),
		.we    (ram_we_flits),
		.waddr (ram_waddr),
		.wdata (wdata_flits),
		.raddr (ram_raddr),
		.rdata (rd_flits)
	);

	always_comb begin
		base_c  = 26'(wait_q[WAIT_W-1:12]) + 26'(hops_q) + 26'(turn_q)
			+ 26'({flits_q - FLITS_W'(1), 1'b0});
		total_c = {base_c, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (op)
				OP_CLEAR, OP_WRITE: begin
					cnt_q <= (cnt_q == LINK_W'(NUM_LINKS - 1)) ? '0 : cnt_q + 1'b1;
				end
				OP_LOAD: begin
					last_phase_q <= current_phase;
					cnt_q        <= '0;
				end
				OP_RESULT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				x_q     <= sx_c;
				y_q     <= sy_c;
				dx_q    <= dx_c;
				dy_q    <= dy_c;
				turn_q  <= (sx_c != dx_c) && (sy_c != dy_c);
				flits_q <= flits_c;
				delta_q <= current_phase - last_phase_q;
				wait_q  <= '0;
				hops_q  <= '0;
			end
			OP_WIN: window_q <= DIVR_W'(delta_q) * DIVR_W'(cfg.phase_len);
			OP_FS: begin
				fs_q  <= 37'(rd_flits) * 37'(cfg.service);
				old_q <= rd_delay;
			end
			OP_RHO_START: sat_q <= DIVR_W'(fs_q) >= window_q;
			OP_ROUTE_RD: begin
				addr_q <= link_c;
				dir_q  <= dir_c;
			end
			OP_ROUTE_UPD: begin
				wait_q <= wait_q + WAIT_W'(rd_delay);
				case (dir_q)
					DIR_XP: begin
						x_q    <= x_q + 1'b1;
						hops_q <= hops_q + HOPS_W'(cfg.hop_x);
					end
					DIR_XN: begin
						x_q    <= x_q - 1'b1;
						hops_q <= hops_q + HOPS_W'(cfg.hop_x);
					end
					DIR_YP: begin
						y_q    <= y_q + 1'b1;
						hops_q <= hops_q + HOPS_W'(cfg.hop_y);
					end
					default: begin
						y_q    <= y_q - 1'b1;
						hops_q <= hops_q + HOPS_W'(cfg.hop_y);
					end
				endcase
			end
			OP_RESULT: rtt_q <= (total_c > 27'(RTT_MAX)) ? RTT_MAX : total_c[RTT_W-1:0];
			default: ;
		endcase
	end

	always_comb begin
		st.cnt_last = cnt_q == LINK_W'(NUM_LINKS - 1);
		st.refresh  = (delta_q != '0) && (window_q != '0);
		st.div_busy = div_busy || (bstep_q != '0);
		st.at_dest  = (x_q == dx_q) && (y_q == dy_q);
		st.out_full = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign rtt_cycles = rtt_q;

endmodule

[rtl/mxq_ctrl.sv]
module mxq_ctrl import mxq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_op_t     op
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WIN,
		S_CHECK,
		S_RD,
		S_FS,
		S_RHO_START,
		S_RHO_WAIT,
		S_FRESH_START,
		S_FRESH_WAIT,
		S_BLEND_START,
		S_BLEND_WAIT,
		S_WRITE,
		S_ROUTE_RD,
		S_ROUTE_UPD,
		S_DONE
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		op       = OP_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (st.cnt_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op       = OP_LOAD;
					state_nx = S_WIN;
				end
			end
			S_WIN: begin
				op       = OP_WIN;
				state_nx = S_CHECK;
			end
			S_CHECK: state_nx = st.refresh ? S_RD : S_ROUTE_RD;
			S_RD: begin
				op       = OP_READ;
				state_nx = S_FS;
			end
			S_FS: begin
				op       = OP_FS;
				state_nx = S_RHO_START;
			end
			S_RHO_START: begin
				op       = OP_RHO_START;
				state_nx = S_RHO_WAIT;
			end
			S_RHO_WAIT: if (!st.div_busy) state_nx = S_FRESH_START;
			S_FRESH_START: begin
				op       = OP_FRESH_START;
				state_nx = S_FRESH_WAIT;
			end
			S_FRESH_WAIT: if (!st.div_busy) state_nx = S_BLEND_START;
			S_BLEND_START: begin
				op       = OP_BLEND_START;
				state_nx = S_BLEND_WAIT;
			end
			S_BLEND_WAIT: if (!st.div_busy) state_nx = S_WRITE;
			S_WRITE: begin
				op       = OP_WRITE;
				state_nx = st.cnt_last ? S_ROUTE_RD : S_RD;
			end
			S_ROUTE_RD: begin
				if (st.at_dest) begin
					state_nx = S_DONE;
				end else begin
					op       = OP_ROUTE_RD;
					state_nx = S_ROUTE_UPD;
				end
			end
			S_ROUTE_UPD: begin
				op       = OP_ROUTE_UPD;
				state_nx = S_ROUTE_RD;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!st.out_full) begin
					op       = OP_RESULT;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[rtl/mesh_xy_latency_queue_estimator.sv]
// Round-trip latency estimator for XY routing on a mesh with per-link queue delays.
// Configuration goes through the APB port (hop_x, hop_y, line size, phase length,
// service time at byte addresses 0, 4, 8, 12, 16); write it only while idle.
// Input words (coordinates, invalidate flag, phase) arrive on in_valid/in_ready;
// one rtt_cycles word per input leaves on out_valid/out_ready.
// The block takes one word at a time. With an unchanged phase a word crosses
// at most 14 links, each through a route read and a route update step.
// When the phase changes, every one of the 256 links is refreshed first through
// the shared shift-subtract divider and a short divide by ten.
// After reset a clearing pass over all 256 links zeroes the link memories; in_ready
// stays low during it while configuration writes are still taken.
// The result sits in an output register; while the receiver stalls, the next
// input word is accepted and processed up to its result, which then holds
// until the register frees.
module mesh_xy_latency_queue_estimator import mxq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] src_x,
	input  logic [COORD_W-1:0] src_y,
	input  logic [COORD_W-1:0] dst_x,
	input  logic [COORD_W-1:0] dst_y,
	input  logic               is_invalidate,
	input  logic [PHASE_W-1:0] current_phase,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RTT_W-1:0]   rtt_cycles
);

	cfg_t       cfg_q;
	dp_status_t st;
	dp_op_t     op;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hop_x     <= 8'd1;
			cfg_q.hop_y     <= 8'd1;
			cfg_q.line_size <= 9'd64;
			cfg_q.phase_len <= 20'd10000;
			cfg_q.service   <= 5'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_HOP_X:   cfg_q.hop_x     <= pwdata[7:0];
				REG_HOP_Y:   cfg_q.hop_y     <= pwdata[7:0];
				REG_LINE:    cfg_q.line_size <= pwdata[8:0];
				REG_PHASE:   cfg_q.phase_len <= pwdata[19:0];
				REG_SERVICE: cfg_q.service   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_HOP_X:   prdata = 32'(cfg_q.hop_x);
			REG_HOP_Y:   prdata = 32'(cfg_q.hop_y);
			REG_LINE:    prdata = 32'(cfg_q.line_size);
			REG_PHASE:   prdata = 32'(cfg_q.phase_len);
			REG_SERVICE: prdata = 32'(cfg_q.service);
			default:     prdata = {30'd0, paddr[1:0]} & 32'd0;
		endcase
	end

	mxq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	mxq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.cfg           (cfg_q),
		.src_x         (src_x),
		.src_y         (src_y),
		.dst_x         (dst_x),
		.dst_y         (dst_y),
		.is_invalidate (is_invalidate),
		.current_phase (current_phase),
		.st            (st),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.rtt_cycles    (rtt_cycles)
	);

`ifndef SYNTHESIS
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in flight");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in flight");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !st.div_busy)
		else $error("divider busy while ready for a new word");
`endif

endmodule
